FILE: rtl/core/egbw_pkg.sv
// Shared types and constants of the Exp-Golomb bitstream writer.
`timescale 1ns / 1ps
`default_nettype none

package egbw_pkg;

   localparam logic [2:0] OP_FIXED = 3'd0;
   localparam logic [2:0] OP_UE    = 3'd1;
   localparam logic [2:0] OP_SE    = 3'd2;
   localparam logic [2:0] OP_TRAIL = 3'd3;
   localparam logic [2:0] OP_FLUSH = 3'd4;

   localparam int DATA_W  = 32;
   localparam int ACC_W   = 72;
   localparam int TBITS_W = 27;
   localparam int CAP_W   = 24;
   localparam int NORM_STEPS = 5;

   typedef struct packed {
      logic       load;
      logic       norm;
      logic [2:0] step;
      logic       pack;
      logic       align;
      logic       emit;
      logic       last;
      logic [2:0] index;
   } cmd_type;

   typedef struct packed {
      logic       need_norm;
      logic [3:0] res_count;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/core/egbw_ctrl.sv
// Sequencer for the Exp-Golomb bitstream writer: load, normalize, pack, align, emit.
`timescale 1ns / 1ps
`default_nettype none

module egbw_ctrl
   import egbw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_NORM  = 3'd1;
   localparam logic [2:0] ST_PACK  = 3'd2;
   localparam logic [2:0] ST_ALIGN = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [2:0] index_ff, index_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       can_issue;
   logic       is_last;

   assign can_issue = !rsp_valid_ff || !rsp_stall;
   assign is_last   = ({1'b0, index_ff} + 4'd1) == status.res_count;
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      index_in     = index_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.step     = step_ff;
      cmd.index    = index_ff;
      cmd.last     = is_last;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = 3'd0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (!status.need_norm) begin
               state_in = ST_PACK;
            end else begin
               cmd.norm = 1'b1;
               step_in  = step_ff + 3'd1;
               if (step_ff == 3'(NORM_STEPS - 1)) begin
                  state_in = ST_PACK;
               end
            end
         end
         ST_PACK: begin
            cmd.pack = 1'b1;
            state_in = ST_ALIGN;
         end
         ST_ALIGN: begin
            cmd.align = 1'b1;
            index_in  = 3'd0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (can_issue) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               index_in     = index_ff + 3'd1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 3'd0;
         index_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/egbw_datapath.sv
// Datapath of the Exp-Golomb bitstream writer: code build, packer, byte counter, result word.
`timescale 1ns / 1ps
`default_nettype none

module egbw_datapath
   import egbw_pkg::*;
#(
   parameter int BYTE_COUNT_BITS = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic [2:0]          req_op,
   input  wire logic [DATA_W-1:0]   req_data_word,
   input  wire logic [5:0]          req_bit_length,
   input  wire logic                csr_wr_en,
   input  wire logic [CAP_W-1:0]    csr_wr_data,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_byte_valid,
   output logic                     rsp_last_of_run,
   output logic                     rsp_byte_aligned,
   output logic [TBITS_W-1:0]       rsp_total_bits,
   output logic                     rsp_overflow,
   output logic                     rsp_bad_value
);

   localparam int TB_W = BYTE_COUNT_BITS + 3;

   // stream state
   logic [7:0]                 partial_ff, partial_in;
   logic [2:0]                 pending_ff, pending_in;
   logic [BYTE_COUNT_BITS-1:0] bw_ff, bw_in;
   logic [CAP_W-1:0]           cap_ff;

   // per-word work registers
   logic [DATA_W-1:0] code_ff, code_in;
   logic [DATA_W-1:0] t_ff, t_in;
   logic [4:0]        m_ff, m_in;
   logic [5:0]        len_ff, len_in;
   logic              bad_ff, bad_in;
   logic              norm_ff, norm_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [6:0]        tot_ff, tot_in;
   logic [ACC_W-1:0]  aligned_ff, aligned_in;
   logic [3:0]        nbytes_ff, nbytes_in;
   logic [3:0]        nacc_ff, nacc_in;

   // result word
   logic [7:0]         out_byte_ff;
   logic               byte_valid_ff;
   logic               last_ff;
   logic               aligned_flag_ff;
   logic [TBITS_W-1:0] total_bits_ff;
   logic               overflow_ff;
   logic               bad_value_ff;

   logic [5:0]        n_sat;
   logic [DATA_W-1:0] fix_mask;
   logic [DATA_W-1:0] se_dbl;
   logic [3:0]        pad_len;
   logic [4:0]        shamt;
   logic [DATA_W-1:0] t_shift;
   logic [5:0]        pack_len;
   logic [32:0]       cmax, limit, bw_wide, headroom;
   logic [3:0]        nb;
   logic [TB_W-1:0]   tb_full;
   logic              byte_ok, is_byte;

   assign n_sat    = (req_bit_length > 6'd32) ? 6'd32 : req_bit_length;
   assign fix_mask = DATA_W'((33'd1 << n_sat) - 33'd1);
   assign se_dbl   = {req_data_word[DATA_W-2:0], 1'b0};
   assign pad_len  = 4'd8 - {1'b0, pending_ff};

   assign shamt    = 5'd16 >> cmd.step;
   assign t_shift  = t_ff >> shamt;
   assign pack_len = norm_ff ? {m_ff, 1'b1} : len_ff;

   assign cmax     = (33'd1 << BYTE_COUNT_BITS) - 33'd1;
   assign limit    = (33'(cap_ff) < cmax) ? 33'(cap_ff) : cmax;
   assign bw_wide  = 33'(bw_ff);
   assign headroom = (limit > bw_wide) ? (limit - bw_wide) : 33'd0;
   assign nb       = tot_ff[6:3];

   assign tb_full  = {bw_ff, pending_ff};
   assign byte_ok  = {1'b0, cmd.index} < nacc_ff;
   assign is_byte  = {1'b0, cmd.index} < nbytes_ff;

   always_comb begin
      code_in    = code_ff;
      t_in       = t_ff;
      m_in       = m_ff;
      len_in     = len_ff;
      bad_in     = bad_ff;
      norm_in    = norm_ff;
      acc_in     = acc_ff;
      tot_in     = tot_ff;
      aligned_in = aligned_ff;
      nbytes_in  = nbytes_ff;
      nacc_in    = nacc_ff;
      partial_in = partial_ff;
      pending_in = pending_ff;
      bw_in      = bw_ff;
      if (cmd.load) begin
         code_in = '0;
         len_in  = 6'd0;
         bad_in  = 1'b0;
         norm_in = 1'b0;
         m_in    = 5'd0;
         case (req_op)
            OP_FIXED: begin
               code_in = req_data_word & fix_mask;
               len_in  = n_sat;
            end
            OP_UE: begin
               if (req_data_word == '1) begin
                  bad_in = 1'b1;
               end else begin
                  code_in = req_data_word + 32'd1;
                  norm_in = 1'b1;
               end
            end
            OP_SE: begin
               if (req_data_word == 32'h8000_0000) begin
                  bad_in = 1'b1;
               end else begin
                  norm_in = 1'b1;
                  if (req_data_word != '0 && !req_data_word[DATA_W-1]) begin
                     code_in = se_dbl;
                  end else begin
                     code_in = (32'd0 - se_dbl) + 32'd1;
                  end
               end
            end
            OP_TRAIL: begin
               len_in  = {2'b00, pad_len};
               code_in = DATA_W'(33'd1 << (pad_len - 4'd1));
            end
            OP_FLUSH: begin
               len_in = (pending_ff == 3'd0) ? 6'd0 : {2'b00, pad_len};
            end
            default: begin
               len_in = 6'd0;
            end
         endcase
         t_in = code_in;
      end
      if (cmd.norm) begin
         if (t_shift != '0) begin
            t_in = t_shift;
            m_in = m_ff + shamt;
         end
      end
      if (cmd.pack) begin
         acc_in = (ACC_W'(partial_ff) << pack_len) | ACC_W'(code_ff);
         tot_in = {4'd0, pending_ff} + {1'b0, pack_len};
      end
      if (cmd.align) begin
         aligned_in = acc_ff << (7'(ACC_W) - tot_ff);
         nbytes_in  = nb;
         nacc_in    = (headroom < 33'(nb)) ? headroom[3:0] : nb;
         pending_in = tot_ff[2:0];
         partial_in = acc_ff[7:0] & 8'((9'd1 << tot_ff[2:0]) - 9'd1);
         bw_in      = bw_ff + BYTE_COUNT_BITS'(nacc_in);
      end
      if (cmd.emit) begin
         aligned_in = aligned_ff << 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 8'd0;
         pending_ff <= 3'd0;
         bw_ff      <= '0;
         cap_ff     <= '1;
      end else begin
         partial_ff <= partial_in;
         pending_ff <= pending_in;
         bw_ff      <= bw_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      code_ff    <= code_in;
      t_ff       <= t_in;
      m_ff       <= m_in;
      len_ff     <= len_in;
      bad_ff     <= bad_in;
      norm_ff    <= norm_in;
      acc_ff     <= acc_in;
      tot_ff     <= tot_in;
      aligned_ff <= aligned_in;
      nbytes_ff  <= nbytes_in;
      nacc_ff    <= nacc_in;
      if (cmd.emit) begin
         out_byte_ff     <= byte_ok ? aligned_ff[ACC_W-1 -: 8] : 8'd0;
         byte_valid_ff   <= byte_ok;
         overflow_ff     <= is_byte && !byte_ok;
         last_ff         <= cmd.last;
         aligned_flag_ff <= (pending_ff == 3'd0);
         total_bits_ff   <= TBITS_W'(tb_full);
         bad_value_ff    <= bad_ff;
      end
   end

   assign status.need_norm = norm_ff;
   assign status.res_count = (nbytes_ff == 4'd0) ? 4'd1 : nbytes_ff;

   assign rsp_out_byte     = out_byte_ff;
   assign rsp_byte_valid   = byte_valid_ff;
   assign rsp_last_of_run  = last_ff;
   assign rsp_byte_aligned = aligned_flag_ff;
   assign rsp_total_bits   = total_bits_ff;
   assign rsp_overflow     = overflow_ff;
   assign rsp_bad_value    = bad_value_ff;

endmodule

`default_nettype wire

FILE: rtl/core/exp_golomb_bitstream_writer_top.sv
// Top level of the Exp-Golomb bitstream writer.
// Packs fixed-length fields, ue(v) and se(v) codes, trailing stop bits and flushes into
// a byte stream, MSB first, one byte per result word. Every request word yields one to
// eight result words; the last one carries last_of_run, and all of them report the
// alignment and bit count after the whole request. Bytes beyond buffer_capacity are
// dropped and flagged with overflow. A fixed-bits, trailing or flush request runs
// accept, a pass-through normalize slot, pack, align, then one emit per result word;
// a ue or se request with a codable value runs the leading-one search as five halving
// steps in place of the pass-through slot. After the first result word, each further
// word follows at one per cycle unless the output is stalled. req_stall is low again
// in the cycle after the last result word is loaded into the output register.
`timescale 1ns / 1ps
`default_nettype none

module exp_golomb_bitstream_writer_top
   import egbw_pkg::*;
#(
   parameter int BYTE_COUNT_BITS = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [2:0]          req_op,
   input  wire logic [DATA_W-1:0]   req_data_word,
   input  wire logic [5:0]          req_bit_length,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_byte_valid,
   output logic                     rsp_last_of_run,
   output logic                     rsp_byte_aligned,
   output logic [TBITS_W-1:0]       rsp_total_bits,
   output logic                     rsp_overflow,
   output logic                     rsp_bad_value,
   input  wire logic                csr_wr_en,
   input  wire logic [CAP_W-1:0]    csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   egbw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   egbw_datapath #(
      .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_data_word    (req_data_word),
      .req_bit_length   (req_bit_length),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_byte_aligned (rsp_byte_aligned),
      .rsp_total_bits   (rsp_total_bits),
      .rsp_overflow     (rsp_overflow),
      .rsp_bad_value    (rsp_bad_value)
   );

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Testbench for the Exp-Golomb bitstream writer: random and directed requests, byte-exact check.
`timescale 1ns / 1ps

module tb;
   import egbw_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_RUN = 8;
   localparam logic [CAP_W-1:0] COUNT_MAX = 24'hFFFFFF;
   localparam logic [2:0] OP_LAST = 3'd7;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               byte_valid;
      logic               last_of_run;
      logic               byte_aligned;
      logic [TBITS_W-1:0] total_bits;
      logic               overflow;
      logic               bad_value;
   } stream_word_type;

   class byte_stream_scoreboard;
      logic [CAP_W-1:0] capacity;
      logic [7:0] shift_reg;
      int fill;
      logic [CAP_W-1:0] bytes_out;
      stream_word_type run[$];
      stream_word_type words_due[$];
      int mismatches, words_seen, requests, kept_bytes, dropped_bytes, rejected;

      function new();
         capacity = COUNT_MAX;
         shift_reg = '0;
         fill = 0;
         bytes_out = '0;
         mismatches = 0;
         words_seen = 0;
         requests = 0;
         kept_bytes = 0;
         dropped_bytes = 0;
         rejected = 0;
      endfunction

      function void emit_byte(logic [7:0] b);
         stream_word_type w;
         bit keep;
         keep = (bytes_out < capacity) && (bytes_out != COUNT_MAX);
         if (run.size() >= MAX_RUN) return;
         w = '0;
         w.out_byte = keep ? b : 8'h00;
         w.byte_valid = keep;
         w.overflow = !keep;
         run.push_back(w);
         if (keep) begin
            bytes_out++;
            kept_bytes++;
         end else begin
            dropped_bytes++;
         end
      endfunction

      function void shift_in(bit b);
         shift_reg = {shift_reg[6:0], b};
         fill++;
         if (fill == 8) begin
            emit_byte(shift_reg);
            shift_reg = '0;
            fill = 0;
         end
      endfunction

      // ue(v): M zeros, then v+1 in M+1 bits
      function void shift_in_code(logic [31:0] value);
         logic [31:0] v;
         int m, i;
         v = value + 32'd1;
         m = 31;
         while (m > 0 && !v[m]) m--;
         repeat (m) shift_in(1'b0);
         for (i = m; i >= 0; i--) shift_in(v[i]);
      endfunction

      function void note_request(logic [2:0] op, logic [31:0] word, logic [5:0] len);
         bit bad;
         int n, i, k;
         stream_word_type w;
         bad = 0;
         run.delete();
         requests++;
         case (op)
            OP_FIXED: begin
               n = (len > 32) ? 32 : len;
               for (i = n - 1; i >= 0; i--) shift_in(word[i]);
            end
            OP_UE: begin
               if (word == 32'hFFFFFFFF) bad = 1;
               else shift_in_code(word);
            end
            OP_SE: begin
               if (word == 32'h80000000) bad = 1;
               else if (word != 32'd0 && !word[31]) shift_in_code((word << 1) - 32'd1);
               else shift_in_code(32'd0 - (word << 1));
            end
            OP_TRAIL: begin
               shift_in(1'b1);
               while (fill != 0) shift_in(1'b0);
            end
            OP_FLUSH: begin
               if (fill > 0) begin
                  emit_byte(shift_reg << (8 - fill));
                  shift_reg = '0;
                  fill = 0;
               end
            end
            default: ;
         endcase
         if (run.size() == 0) begin
            w = '0;
            run.push_back(w);
         end
         if (bad) rejected++;
         for (k = 0; k < run.size(); k++) begin
            w = run[k];
            w.last_of_run = (k == run.size() - 1);
            w.byte_aligned = (fill == 0);
            w.total_bits = {bytes_out, 3'(fill)};
            w.bad_value = bad;
            words_due.push_back(w);
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(stream_word_type got);
         stream_word_type want;
         words_seen++;
         if (words_due.size() == 0) begin
            $error("result word with nothing pending: out_byte %0h", got.out_byte);
            mismatches++;
            return;
         end
         want = words_due.pop_front();
         compare_field("out_byte", want.out_byte, got.out_byte);
         compare_field("byte_valid", want.byte_valid, got.byte_valid);
         compare_field("last_of_run", want.last_of_run, got.last_of_run);
         compare_field("byte_aligned", want.byte_aligned, got.byte_aligned);
         compare_field("total_bits", want.total_bits, got.total_bits);
         compare_field("overflow", want.overflow, got.overflow);
         compare_field("bad_value", want.bad_value, got.bad_value);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_op;
   logic [DATA_W-1:0] req_data_word;
   logic [5:0] req_bit_length;
   logic rsp_valid;
   logic rsp_stall;
   logic [7:0] rsp_out_byte;
   logic rsp_byte_valid;
   logic rsp_last_of_run;
   logic rsp_byte_aligned;
   logic [TBITS_W-1:0] rsp_total_bits;
   logic rsp_overflow;
   logic rsp_bad_value;
   logic csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   stream_word_type rsp_word;
   byte_stream_scoreboard sb = new();
   int cycle_count = 0;
   int settings_used = 0;
   int holds_done = 0;
   bit tx_calm = 0;
   bit rx_calm = 0;
   bit hold_request = 0;

   exp_golomb_bitstream_writer_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_data_word(req_data_word),
      .req_bit_length(req_bit_length),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_byte_aligned(rsp_byte_aligned),
      .rsp_total_bits(rsp_total_bits),
      .rsp_overflow(rsp_overflow),
      .rsp_bad_value(rsp_bad_value),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   assign rsp_word = {rsp_out_byte, rsp_byte_valid, rsp_last_of_run, rsp_byte_aligned,
                      rsp_total_bits, rsp_overflow, rsp_bad_value};

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_word);
   end

   // receiver: random stalls, calm stretches, one long hold on request
   initial begin
      int stall_left, free_left, hold_left, r;
      stall_left = 0;
      free_left = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_request) begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rx_calm) begin
            rsp_stall <= 1'b0;
         end else begin
            if (stall_left == 0 && free_left == 0) begin
               r = $urandom_range(0, 99);
               if (r < 10) begin
                  free_left = $urandom_range(20, 60);
               end else begin
                  free_left = $urandom_range(0, 4);
                  stall_left = (r < 85) ? $urandom_range(1, 3) : $urandom_range(15, 40);
               end
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else begin
               free_left--;
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   task automatic send_request(input logic [2:0] op, input logic [31:0] word,
                               input logic [5:0] len);
      int gap, r;
      r = $urandom_range(0, 99);
      if (tx_calm || r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_data_word <= word;
      req_bit_length <= len;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, word, len);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.capacity = value;
      settings_used++;
   endtask

   task automatic run_random(input int count);
      int i, r, k;
      logic [2:0] op;
      logic [31:0] word;
      logic [5:0] len;
      for (i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 30) op = OP_FIXED;
         else if (r < 55) op = OP_UE;
         else if (r < 80) op = OP_SE;
         else if (r < 88) op = OP_TRAIL;
         else if (r < 95) op = OP_FLUSH;
         else op = 3'($urandom_range(OP_FLUSH + 3'd1, OP_LAST));
         case ($urandom_range(0, 39))
            0: word = 32'hFFFFFFFF;
            1: word = 32'h80000000;
            2: word = 32'h7FFFFFFF;
            3: word = 32'hFFFFFFFE;
            default: begin
               k = $urandom_range(0, 32);
               word = $urandom;
               if (k < 32) word = word & ((32'd1 << k) - 32'd1);
               if (op == OP_SE && $urandom_range(0, 1) == 1) word = 32'd0 - word;
            end
         endcase
         if ($urandom_range(0, 19) == 0) len = 6'($urandom_range(0, 63));
         else len = 6'($urandom_range(1, 32));
         send_request(op, word, len);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_FIXED;
      req_data_word = '0;
      req_bit_length = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(OP_FIXED, 32'h00000001, 6'd1);
      send_request(OP_FIXED, 32'hFFFFFFFF, 6'd32);
      send_request(OP_FIXED, 32'hDEADBEEF, 6'd0);
      send_request(OP_FIXED, 32'hA5A5A5A5, 6'd63);
      send_request(OP_FIXED, 32'h12345678, 6'd33);
      send_request(OP_UE, 32'h00000000, 6'd0);
      send_request(OP_UE, 32'hFFFFFFFE, 6'd0);
      send_request(OP_UE, 32'hFFFFFFFF, 6'd0);
      send_request(OP_SE, 32'h00000000, 6'd0);
      send_request(OP_SE, 32'h00000001, 6'd0);
      send_request(OP_SE, 32'hFFFFFFFF, 6'd0);
      send_request(OP_SE, 32'h7FFFFFFF, 6'd0);
      send_request(OP_SE, 32'h80000000, 6'd0);
      send_request(OP_SE, 32'h80000001, 6'd0);
      send_request(OP_TRAIL, 32'h00000000, 6'd0);
      send_request(OP_TRAIL, 32'h00000000, 6'd0);
      send_request(OP_FLUSH, 32'h00000000, 6'd0);
      send_request(OP_FIXED, 32'h00000005, 6'd3);
      send_request(OP_FLUSH, 32'h00000000, 6'd0);
      send_request(OP_FLUSH + 3'd1, 32'hFFFFFFFF, 6'd63);
      send_request(OP_FLUSH + 3'd2, 32'h55555555, 6'd21);
      send_request(OP_LAST, 32'hAAAAAAAA, 6'd42);
      settle();

      // capacity zero: every byte dropped
      write_capacity('0);
      run_random(94);
      settle();

      // capacity runs out partway through
      write_capacity(sb.bytes_out + 24'd40);
      run_random(94);
      settle();

      // no idling on either side
      write_capacity(CAP_W'($urandom_range(1, COUNT_MAX)));
      tx_calm = 1;
      rx_calm = 1;
      run_random(94);
      tx_calm = 0;
      rx_calm = 0;
      settle();

      write_capacity(sb.bytes_out + 24'd15);
      run_random(94);
      settle();

      // full capacity, long output hold while requests keep coming
      write_capacity(COUNT_MAX);
      hold_request = 1;
      tx_calm = 1;
      run_random(40);
      tx_calm = 0;
      run_random(54);
      settle();

      $display("Covered %0d requests, %0d result words: %0d bytes kept, %0d dropped",
               sb.requests, sb.words_seen, sb.kept_bytes, sb.dropped_bytes);
      $display("%0d uncodable values, %0d capacity settings, %0d long output holds",
               sb.rejected, settings_used, holds_done);
      if (sb.mismatches == 0 && sb.words_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: exp_golomb_bitstream_writer_top.f
rtl/core/egbw_pkg.sv
rtl/core/egbw_ctrl.sv
rtl/core/egbw_datapath.sv
rtl/core/exp_golomb_bitstream_writer_top.sv
sim/tb.sv
